FILE: hw/rtl/fmva_pkg.sv
// ----------------------------------------------------------------------------
// fmva_pkg
// Shared types and constants of the FM voice allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fmva_pkg;

  localparam int VOICES_DEF    = 18;
  localparam int TIME_BITS_DEF = 32;

  localparam int ACT_W     = 2;
  localparam int CH_W      = 4;
  localparam int KEY_W     = 7;
  localparam int VEL_W     = 7;
  localparam int TIME_IN_W = 32;
  localparam int IDX_W     = 5;
  localparam int MASK_W    = 18;
  localparam int VIU_W     = 5;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam logic [ACT_W-1:0] ACT_NOTE_ON  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_NOTE_OFF = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY    = 2'd2;

  localparam logic [VIU_W-1:0] VIU_RESET = 5'd18;
  localparam logic             REG_VIU   = 1'b0;

  localparam logic [CH_W-1:0]  PERC_CH   = 4'd9;
  localparam logic [KEY_W-1:0] KEY_A_IN  = 7'd85;
  localparam logic [KEY_W-1:0] KEY_A_OUT = 7'd37;
  localparam logic [KEY_W-1:0] KEY_B_IN  = 7'd82;
  localparam logic [KEY_W-1:0] KEY_B_OUT = 7'd44;
  localparam logic [KEY_W-1:0] KEY_LO    = 7'd35;
  localparam logic [KEY_W-1:0] KEY_HI    = 7'd81;

  typedef struct packed {
    logic [ACT_W-1:0]     action;
    logic [CH_W-1:0]      channel;
    logic [KEY_W-1:0]     key;
    logic [VEL_W-1:0]     velocity;
    logic [TIME_IN_W-1:0] start_time;
    logic                 double_voice;
  } in_item_t;

  typedef struct packed {
    logic              voice_valid;
    logic [IDX_W-1:0]  voice_index;
    logic [MASK_W-1:0] voice_mask;
    logic              last;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE
  } state_t;

  typedef enum logic [1:0] {
    M_ALLOC,
    M_RELEASE,
    M_QUERY
  } mode_t;

endpackage

`default_nettype wire

FILE: hw/rtl/fmva_ram.sv
// ----------------------------------------------------------------------------
// fmva_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fmva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fmva_cfg.sv
// ----------------------------------------------------------------------------
// fmva_cfg
// APB register file: holds the searched voice count.
// ----------------------------------------------------------------------------
`default_nettype none

module fmva_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [fmva_pkg::APB_AW-1:0] paddr,
  input  wire logic [fmva_pkg::APB_DW-1:0] pwdata,
  output logic      [fmva_pkg::APB_DW-1:0] prdata,
  output logic                             pready,
  output logic      [fmva_pkg::VIU_W-1:0]  voices_in_use
);

  logic [fmva_pkg::VIU_W-1:0] viu_r;
  logic [fmva_pkg::VIU_W-1:0] viu_nxt;
  logic                       sel_viu;

  assign pready  = 1'b1;
  assign sel_viu = (paddr[fmva_pkg::APB_AW-1] == fmva_pkg::REG_VIU);

  always_comb begin
    viu_nxt = viu_r;
    if (psel && penable && pwrite && sel_viu) begin
      viu_nxt = pwdata[fmva_pkg::VIU_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      viu_r <= fmva_pkg::VIU_RESET;
    end else begin
      viu_r <= viu_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_viu) begin
      prdata = {{(fmva_pkg::APB_DW - fmva_pkg::VIU_W){1'b0}}, viu_r};
    end
  end

  assign voices_in_use = viu_r;

endmodule

`default_nettype wire

FILE: hw/rtl/fmva_ctrl.sv
// ----------------------------------------------------------------------------
// fmva_ctrl
// Event sequencer: scans the voice table, picks, releases or reports voices.
// ----------------------------------------------------------------------------
`default_nettype none

module fmva_ctrl #(
  parameter int VOICES    = fmva_pkg::VOICES_DEF,
  parameter int TIME_BITS = fmva_pkg::TIME_BITS_DEF,
  parameter int IW        = $clog2(VOICES),
  parameter int REC_W     = TIME_BITS + 2 + fmva_pkg::CH_W + fmva_pkg::KEY_W
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire fmva_pkg::in_item_t         in_item,
  output logic                            busy,
  input  wire logic [fmva_pkg::VIU_W-1:0] voices_in_use,
  output logic                            ram_we,
  output logic      [IW-1:0]              ram_waddr,
  output logic      [REC_W-1:0]           ram_wdata,
  output logic      [IW-1:0]              ram_raddr,
  input  wire logic [REC_W-1:0]           ram_rdata,
  output logic                            out_valid,
  output fmva_pkg::out_item_t             out_item
);

  localparam int CW    = $clog2(VOICES + 1);
  localparam int CH_HI = REC_W - 3;
  localparam int KY_HI = REC_W - 3 - fmva_pkg::CH_W;

  fmva_pkg::state_t state_r, state_nxt;
  fmva_pkg::mode_t  mode_r, mode_nxt;

  logic [fmva_pkg::CH_W-1:0]  ch_r, ch_nxt;
  logic [fmva_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [TIME_BITS-1:0]       time_r, time_nxt;
  logic                       dbl_r, dbl_nxt;
  logic                       second_r, second_nxt;
  logic [CW-1:0]              iss_r, iss_nxt;
  logic [CW-1:0]              ev_r, ev_nxt;
  logic                       ev_valid_r, ev_valid_nxt;
  logic [IW-1:0]              best_idx_r, best_idx_nxt;
  logic [TIME_BITS-1:0]       best_time_r, best_time_nxt;
  logic [IW-1:0]              pick_r, pick_nxt;
  logic [VOICES-1:0]          mask_r, mask_nxt;
  logic [VOICES-1:0]          vbits_r, vbits_nxt;
  logic                       rd_valid_r, rd_valid_nxt;
  logic                       out_valid_r, out_valid_nxt;
  fmva_pkg::out_item_t        out_item_r, out_item_nxt;

  logic [CW-1:0]              n_srch;
  logic                       accept;
  logic [fmva_pkg::KEY_W-1:0] key_map;
  logic                       perc_drop;
  logic                       go;
  logic                       issuing;
  logic                       last_ev;
  logic [IW-1:0]              ev_idx;
  logic [REC_W-1:0]           rec;
  logic                       rec_active;
  logic                       rec_assigned;
  logic [fmva_pkg::CH_W-1:0]  rec_ch;
  logic [fmva_pkg::KEY_W-1:0] rec_key;
  logic [TIME_BITS-1:0]       rec_time;
  logic                       better;
  logic                       hit;
  logic                       alloc_more;
  logic [VOICES-1:0]          ev_bit;
  logic [VOICES-1:0]          mask_acc;
  logic [VOICES+fmva_pkg::MASK_W-1:0]       mask_ext;
  logic [IW+fmva_pkg::IDX_W-1:0]            idx_ext;
  logic [TIME_BITS+fmva_pkg::TIME_IN_W-1:0] tm_ext;

  always_comb begin
    if (voices_in_use == '0) begin
      n_srch = CW'(1);
    end else if (int'(voices_in_use) > VOICES) begin
      n_srch = CW'(VOICES);
    end else begin
      n_srch = CW'(voices_in_use);
    end
  end

  assign accept = start && (state_r == fmva_pkg::S_IDLE);
  assign busy   = (state_r != fmva_pkg::S_IDLE);

  always_comb begin
    key_map = in_item.key;
    if (in_item.key == fmva_pkg::KEY_A_IN) begin
      key_map = fmva_pkg::KEY_A_OUT;
    end else if (in_item.key == fmva_pkg::KEY_B_IN) begin
      key_map = fmva_pkg::KEY_B_OUT;
    end
  end

  assign perc_drop = (in_item.channel == fmva_pkg::PERC_CH) &&
                     ((key_map < fmva_pkg::KEY_LO) || (key_map > fmva_pkg::KEY_HI));
  assign go = ((in_item.action == fmva_pkg::ACT_NOTE_ON) && !perc_drop) ||
              (in_item.action == fmva_pkg::ACT_NOTE_OFF) ||
              (in_item.action == fmva_pkg::ACT_QUERY);

  assign issuing   = (state_r == fmva_pkg::S_SCAN) && (iss_r < n_srch);
  assign ram_raddr = issuing ? iss_r[IW-1:0] : '0;

  assign ev_idx       = ev_r[IW-1:0];
  assign last_ev      = (ev_r == (n_srch - CW'(1)));
  assign rec          = rd_valid_r ? ram_rdata : '0;
  assign rec_active   = rec[REC_W-1];
  assign rec_assigned = rec[REC_W-2];
  assign rec_ch       = rec[CH_HI -: fmva_pkg::CH_W];
  assign rec_key      = rec[KY_HI -: fmva_pkg::KEY_W];
  assign rec_time     = rec[TIME_BITS-1:0];
  assign better       = (ev_r == '0) || (rec_time < best_time_r);
  assign ev_bit       = VOICES'(1) << ev_idx;
  assign alloc_more   = dbl_r && !second_r;
  assign tm_ext       = {{TIME_BITS{1'b0}}, in_item.start_time};
  assign idx_ext      = {{fmva_pkg::IDX_W{1'b0}}, pick_r};

  always_comb begin
    hit = 1'b0;
    case (mode_r)
      fmva_pkg::M_RELEASE: hit = rec_assigned && (rec_ch == ch_r) && (rec_key == key_r);
      fmva_pkg::M_QUERY:   hit = rec_assigned && rec_active && (rec_ch == ch_r);
      default:             hit = 1'b0;
    endcase
  end

  assign mask_acc = mask_r | (hit ? ev_bit : '0);
  assign mask_ext = {{fmva_pkg::MASK_W{1'b0}}, mask_acc};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fmva_pkg::S_IDLE: begin
        if (accept && go) begin
          state_nxt = fmva_pkg::S_SCAN;
        end
      end
      fmva_pkg::S_SCAN: begin
        if (ev_valid_r) begin
          if (mode_r == fmva_pkg::M_ALLOC) begin
            if (!rec_active || last_ev) begin
              state_nxt = fmva_pkg::S_WRITE;
            end
          end else if (last_ev) begin
            state_nxt = fmva_pkg::S_IDLE;
          end
        end
      end
      fmva_pkg::S_WRITE: begin
        state_nxt = alloc_more ? fmva_pkg::S_SCAN : fmva_pkg::S_IDLE;
      end
      default: state_nxt = fmva_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    mode_nxt      = mode_r;
    ch_nxt        = ch_r;
    key_nxt       = key_r;
    time_nxt      = time_r;
    dbl_nxt       = dbl_r;
    second_nxt    = second_r;
    iss_nxt       = '0;
    ev_nxt        = ev_r;
    ev_valid_nxt  = 1'b0;
    best_idx_nxt  = best_idx_r;
    best_time_nxt = best_time_r;
    pick_nxt      = pick_r;
    mask_nxt      = mask_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    ram_we        = 1'b0;
    ram_waddr     = ev_idx;
    ram_wdata     = {1'b0, rec[REC_W-2:0]};
    case (state_r)
      fmva_pkg::S_IDLE: begin
        if (accept) begin
          ch_nxt     = in_item.channel;
          key_nxt    = in_item.key;
          time_nxt   = tm_ext[TIME_BITS-1:0];
          dbl_nxt    = in_item.double_voice;
          second_nxt = 1'b0;
          mask_nxt   = '0;
          if (in_item.action == fmva_pkg::ACT_QUERY) begin
            mode_nxt = fmva_pkg::M_QUERY;
          end else if ((in_item.action == fmva_pkg::ACT_NOTE_ON) &&
                       (in_item.velocity != '0)) begin
            mode_nxt = fmva_pkg::M_ALLOC;
          end else begin
            mode_nxt = fmva_pkg::M_RELEASE;
          end
        end
      end
      fmva_pkg::S_SCAN: begin
        if (issuing) begin
          iss_nxt      = iss_r + CW'(1);
          ev_nxt       = iss_r;
          ev_valid_nxt = 1'b1;
        end else begin
          iss_nxt = iss_r;
        end
        if (ev_valid_r) begin
          if (mode_r == fmva_pkg::M_ALLOC) begin
            if (better) begin
              best_idx_nxt  = ev_idx;
              best_time_nxt = rec_time;
            end
            if (!rec_active) begin
              pick_nxt = ev_idx;
            end else if (last_ev) begin
              pick_nxt = better ? ev_idx : best_idx_r;
            end
          end else begin
            mask_nxt = mask_acc;
            ram_we   = hit && (mode_r == fmva_pkg::M_RELEASE);
            if (last_ev) begin
              out_valid_nxt            = 1'b1;
              out_item_nxt.voice_valid = 1'b0;
              out_item_nxt.voice_index = '0;
              out_item_nxt.voice_mask  = mask_ext[fmva_pkg::MASK_W-1:0];
              out_item_nxt.last        = 1'b1;
            end
          end
        end
      end
      fmva_pkg::S_WRITE: begin
        ram_we                   = 1'b1;
        ram_waddr                = pick_r;
        ram_wdata                = {1'b1, 1'b1, ch_r, key_r, time_r};
        out_valid_nxt            = 1'b1;
        out_item_nxt.voice_valid = 1'b1;
        out_item_nxt.voice_index = idx_ext[fmva_pkg::IDX_W-1:0];
        out_item_nxt.voice_mask  = '0;
        out_item_nxt.last        = !alloc_more;
        second_nxt               = 1'b1;
      end
      default: begin
        iss_nxt = '0;
      end
    endcase
  end

  always_comb begin
    vbits_nxt = vbits_r;
    if (ram_we) begin
      vbits_nxt[ram_waddr] = 1'b1;
    end
  end

  assign rd_valid_nxt = vbits_r[ram_raddr];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fmva_pkg::S_IDLE;
      mode_r      <= fmva_pkg::M_ALLOC;
      second_r    <= 1'b0;
      iss_r       <= '0;
      ev_valid_r  <= 1'b0;
      vbits_r     <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      second_r    <= second_nxt;
      iss_r       <= iss_nxt;
      ev_valid_r  <= ev_valid_nxt;
      vbits_r     <= vbits_nxt;
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r        <= ch_nxt;
    key_r       <= key_nxt;
    time_r      <= time_nxt;
    dbl_r       <= dbl_nxt;
    ev_r        <= ev_nxt;
    best_idx_r  <= best_idx_nxt;
    best_time_r <= best_time_nxt;
    pick_r      <= pick_nxt;
    mask_r      <= mask_nxt;
    out_item_r  <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

FILE: hw/rtl/fm_voice_allocator.sv
// ----------------------------------------------------------------------------
// fm_voice_allocator
// Note event to synthesizer voice allocator with oldest-note stealing.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_item and raise start; the event beat is taken when start
//   is high and busy is low. busy stays high until the event is finished.
//   Output: each result is shown for one cycle with out_valid high; the
//   receiver cannot stall, so results must be taken as they appear.
//   Configuration: APB register 0 (voices_in_use) at byte address 0, to be
//   written only while the block is idle; not enforced. pready is tied high.
//   Operation, with N searched voices: every note or query event that is not
//   dropped walks the voice table in the RAM, one entry per cycle, with registered read data.
//   Note off and channel query: all N entries read, result in the cycle after busy.
//   Note on: the walk stops at the first free voice, result in the cycle after
//   busy; double-voice note on repeats the walk for the second voice.
//   Dropped percussion keys and unknown actions never raise busy and give no result.
//   Reset: synchronous, active low; all voices read as free and unassigned
//   at once through per-entry valid bits, voices_in_use returns to 18.
// ----------------------------------------------------------------------------
`default_nettype none

module fm_voice_allocator #(
  parameter int VOICES    = fmva_pkg::VOICES_DEF,
  parameter int TIME_BITS = fmva_pkg::TIME_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire fmva_pkg::in_item_t          in_item,
  output logic                             out_valid,
  output fmva_pkg::out_item_t              out_item,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [fmva_pkg::APB_AW-1:0] paddr,
  input  wire logic [fmva_pkg::APB_DW-1:0] pwdata,
  output logic      [fmva_pkg::APB_DW-1:0] prdata,
  output logic                             pready
);

  localparam int IW    = $clog2(VOICES);
  localparam int REC_W = TIME_BITS + 2 + fmva_pkg::CH_W + fmva_pkg::KEY_W;

  logic [fmva_pkg::VIU_W-1:0] voices_in_use;
  logic                       ram_we;
  logic [IW-1:0]              ram_waddr;
  logic [REC_W-1:0]           ram_wdata;
  logic [IW-1:0]              ram_raddr;
  logic [REC_W-1:0]           ram_rdata;

  fmva_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .voices_in_use (voices_in_use)
  );

  fmva_ram #(
    .WIDTH (REC_W),
    .DEPTH (VOICES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fmva_ctrl #(
    .VOICES    (VOICES),
    .TIME_BITS (TIME_BITS),
    .IW        (IW),
    .REC_W     (REC_W)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_item       (in_item),
    .busy          (busy),
    .voices_in_use (voices_in_use),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .out_valid     (out_valid),
    .out_item      (out_item)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/fmva_checker.sv
// ----------------------------------------------------------------------------
// fmva_checker
// Port-level assertions for the voice allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fmva_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                out_valid,
  input wire fmva_pkg::out_item_t out_item
);

  // drop all activity after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("busy or out_valid after reset");

  // a result beat only follows work in progress
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without preceding work");

  // hold busy while the second voice is still pending
  a_first_of_two: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |-> busy)
    else $error("non-final result while idle");

  // a final result beat is followed by a gap without a result beat
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last |=> !out_valid)
    else $error("result beat right after final beat");

  // hold results off in the cycle after a new event beat
  a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> !out_valid)
    else $error("result beat right after an accepted event");

endmodule

bind fm_voice_allocator fmva_checker u_fmva_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

`default_nettype wire
